@@ rtl/jbhe_pkg.sv @@
// Shared types, constants and helpers of the JPEG block Huffman encoder.
package jbhe_pkg;

   // Design constants
   localparam int COMPONENTS = 4;
   localparam int COEFF_BITS = 12;
   localparam int CoeffInW   = 12;
   localparam int CompW      = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
   localparam int CalcW      = ((COEFF_BITS > CoeffInW) ? COEFF_BITS : CoeffInW) + 1;
   localparam int NbW        = $clog2(COEFF_BITS + 1);
   localparam int AmpW       = COEFF_BITS;
   localparam int AmpMaskW   = AmpW + 1;
   localparam int CodeW      = 16;
   localparam int LenW       = 5;
   localparam int EntryW     = LenW + CodeW;
   localparam int ValW       = CodeW + COEFF_BITS;
   localparam int TotW       = $clog2(CodeW + COEFF_BITS + 1);
   localparam int BitsW      = 28;
   localparam int CountW     = 5;
   localparam int RunW       = 6;
   localparam int JobDepth   = 4;
   localparam int JobPtrW    = $clog2(JobDepth);
   localparam int DcDepth    = 16;
   localparam int AcDepth    = 256;

   localparam logic signed [CalcW-1:0] COEFF_HI = CalcW'((2 ** (COEFF_BITS - 1)) - 1);
   localparam logic signed [CalcW-1:0] COEFF_LO = ~COEFF_HI;

   localparam logic [7:0]        SYM_ZRL   = 8'hF0;
   localparam logic [7:0]        SYM_EOB   = 8'h00;
   localparam logic [RunW-1:0]   RUN_CAP   = 6'd63;
   localparam logic [5:0]        POS_DC    = 6'd0;
   localparam logic [5:0]        POS_LAST  = 6'd63;
   localparam logic [LenW-1:0]   LEN_MAX   = 5'd16;
   localparam logic [TotW-1:0]   COUNT_MAX = TotW'(BitsW);

   // Command codes on the input word
   typedef enum logic [1:0] {
      CMD_COEFF    = 2'd0,
      CMD_DC_WRITE = 2'd1,
      CMD_AC_WRITE = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   // Job kinds between front and back
   typedef enum logic [1:0] {
      JOB_CODE     = 2'd0,
      JOB_DC_WRITE = 2'd1,
      JOB_AC_WRITE = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic [1:0]              command;
      logic signed [CoeffInW-1:0] coefficient;
      logic [5:0]              position;
      logic [1:0]              component;
      logic [1:0]              extra_zrls;
      logic [7:0]              table_symbol;
      logic [15:0]             table_code;
      logic [4:0]              table_length;
   } req_word_type;

   typedef struct packed {
      logic [BitsW-1:0]  bits;
      logic [CountW-1:0] bit_count;
      logic              block_end;
   } rsp_word_type;

   // One classified item: leading ZRLs, main symbol, trailing ZRLs, EOB
   typedef struct packed {
      job_kind_type      kind;
      logic [1:0]        lead_zrl;
      logic              has_main;
      logic              main_dc;
      logic [7:0]        main_sym;
      logic [NbW-1:0]    nb;
      logic [AmpW-1:0]   amp;
      logic [1:0]        tail_zrl;
      logic              eob;
      logic              block_end;
      logic [7:0]        wr_addr;
      logic [EntryW-1:0] wr_entry;
   } job_type;

   // Size category: index of the highest set bit plus one
   function automatic logic [NbW-1:0] mag_bits(input logic [CalcW-1:0] mag);
      logic [NbW-1:0] n;
      n = '0;
      for (int i = 0; i < CalcW; i++) begin
         if (mag[i]) n = NbW'(i + 1);
      end
      return n;
   endfunction

endpackage

@@ rtl/jbhe_front.sv @@
// Front end: accepts words, tracks predictors and zero run, classifies into jobs.
module jbhe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  jbhe_pkg::req_word_type req_word,
   input  logic                  job_full,
   output logic                  job_push,
   output jbhe_pkg::job_type     job_word
);

   logic accept;
   logic need_job;

   logic signed [jbhe_pkg::CalcW-1:0] coef_ext;
   logic signed [jbhe_pkg::CalcW-1:0] coef_v;
   logic signed [jbhe_pkg::CalcW-1:0] pred_ext;
   logic signed [jbhe_pkg::CalcW-1:0] val;
   logic [jbhe_pkg::CalcW-1:0]        mag;
   logic [jbhe_pkg::NbW-1:0]          nb;
   logic [jbhe_pkg::AmpW-1:0]         amp;
   logic [jbhe_pkg::CompW-1:0]        comp_sel;
   logic [jbhe_pkg::RunW-1:0]         run_inc;
   logic [jbhe_pkg::LenW-1:0]         tlen;
   logic                              is_dc;
   logic                              is_last;
   logic                              is_zero;

   logic [jbhe_pkg::RunW-1:0]         run_ff, run_in;
   logic signed [jbhe_pkg::COEFF_BITS-1:0] pred_ff [jbhe_pkg::COMPONENTS];
   logic signed [jbhe_pkg::COEFF_BITS-1:0] pred_in [jbhe_pkg::COMPONENTS];

   assign accept = req_push && !job_full;

   // Clamp the coefficient and pick the predictor
   always_comb begin
      coef_ext = jbhe_pkg::CalcW'(req_word.coefficient);
      if (coef_ext < jbhe_pkg::COEFF_LO) begin
         coef_v = jbhe_pkg::COEFF_LO;
      end else if (coef_ext > jbhe_pkg::COEFF_HI) begin
         coef_v = jbhe_pkg::COEFF_HI;
      end else begin
         coef_v = coef_ext;
      end
      if (int'(req_word.component) >= jbhe_pkg::COMPONENTS) begin
         comp_sel = jbhe_pkg::CompW'(jbhe_pkg::COMPONENTS - 1);
      end else begin
         comp_sel = jbhe_pkg::CompW'(req_word.component);
      end
      pred_ext = jbhe_pkg::CalcW'(pred_ff[comp_sel]);
   end

   // Size category and ones-complement amplitude
   always_comb begin
      is_dc   = (req_word.position == jbhe_pkg::POS_DC);
      is_last = (req_word.position == jbhe_pkg::POS_LAST);
      is_zero = (coef_v == '0);
      val     = is_dc ? (coef_v - pred_ext) : coef_v;
      mag     = val[jbhe_pkg::CalcW-1] ? jbhe_pkg::CalcW'(-val) : jbhe_pkg::CalcW'(val);
      nb      = jbhe_pkg::mag_bits(mag);
      amp     = val[jbhe_pkg::CalcW-1] ? jbhe_pkg::AmpW'(val - jbhe_pkg::CalcW'(1))
                                       : jbhe_pkg::AmpW'(val);
      run_inc = (run_ff == jbhe_pkg::RUN_CAP) ? run_ff : run_ff + 1'b1;
      tlen    = (req_word.table_length > jbhe_pkg::LEN_MAX) ? jbhe_pkg::LEN_MAX
                                                            : req_word.table_length;
   end

   // Classify the word into a job
   always_comb begin
      job_word          = '0;
      job_word.kind     = jbhe_pkg::JOB_CODE;
      job_word.wr_addr  = req_word.table_symbol;
      job_word.wr_entry = {tlen, req_word.table_code};
      need_job          = 1'b0;
      case (req_word.command)
         jbhe_pkg::CMD_COEFF: begin
            if (is_dc) begin
               need_job          = 1'b1;
               job_word.has_main = 1'b1;
               job_word.main_dc  = 1'b1;
               job_word.main_sym = {4'b0, nb[3:0]};
               job_word.nb       = nb;
               job_word.amp      = amp;
            end else if (!is_zero) begin
               need_job           = 1'b1;
               job_word.lead_zrl  = run_ff[5:4];
               job_word.has_main  = 1'b1;
               job_word.main_sym  = {run_ff[3:0], 4'b0} + 8'(nb);
               job_word.nb        = nb;
               job_word.amp       = amp;
               job_word.tail_zrl  = is_last ? req_word.extra_zrls : 2'd0;
               job_word.block_end = is_last;
            end else if (is_last) begin
               need_job           = 1'b1;
               job_word.tail_zrl  = req_word.extra_zrls;
               job_word.eob       = run_inc > {req_word.extra_zrls, 4'b0};
               job_word.block_end = 1'b1;
            end
         end
         jbhe_pkg::CMD_DC_WRITE: begin
            job_word.kind = jbhe_pkg::JOB_DC_WRITE;
            need_job      = (req_word.table_symbol < 8'(jbhe_pkg::DcDepth));
         end
         jbhe_pkg::CMD_AC_WRITE: begin
            job_word.kind = jbhe_pkg::JOB_AC_WRITE;
            need_job      = 1'b1;
         end
         default: begin
            need_job = 1'b0;
         end
      endcase
   end

   assign job_push = accept && need_job;

   // Advance run counter and predictors
   always_comb begin
      run_in  = run_ff;
      pred_in = pred_ff;
      if (accept) begin
         case (req_word.command)
            jbhe_pkg::CMD_COEFF: begin
               if (is_dc) begin
                  run_in            = '0;
                  pred_in[comp_sel] = jbhe_pkg::COEFF_BITS'(coef_v);
               end else if (is_last || !is_zero) begin
                  run_in = '0;
               end else begin
                  run_in = run_inc;
               end
            end
            jbhe_pkg::CMD_CLEAR: begin
               for (int i = 0; i < jbhe_pkg::COMPONENTS; i++) begin
                  pred_in[i] = '0;
               end
            end
            default: begin
               run_in = run_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         for (int i = 0; i < jbhe_pkg::COMPONENTS; i++) begin
            pred_ff[i] <= '0;
         end
      end else begin
         run_ff  <= run_in;
         pred_ff <= pred_in;
      end
   end

endmodule

@@ rtl/jbhe_job_queue.sv @@
// Short job queue between front end and back end.
module jbhe_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jbhe_pkg::job_type push_word,
   output logic              full,
   input  logic              pop,
   output jbhe_pkg::job_type head_word,
   output logic              empty
);

   jbhe_pkg::job_type            entry_ff [jbhe_pkg::JobDepth];
   logic [jbhe_pkg::JobPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jbhe_pkg::JobPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jbhe_pkg::JobPtrW:0]   count_ff, count_in;

   assign full      = (count_ff == (jbhe_pkg::JobPtrW + 1)'(jbhe_pkg::JobDepth));
   assign empty     = (count_ff == '0);
   assign head_word = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_word;
   end

endmodule

@@ rtl/jbhe_back.sv @@
// Back end: code tables, per-result sequencer and output register.
module jbhe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jbhe_pkg::job_type      job_head,
   input  logic                   job_empty,
   output logic                   job_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output jbhe_pkg::rsp_word_type rsp_word
);

   // Code tables
   logic [jbhe_pkg::EntryW-1:0] ac_mem      [jbhe_pkg::AcDepth];
   logic                        ac_valid_ff [jbhe_pkg::AcDepth];
   logic [jbhe_pkg::EntryW-1:0] dc_table_ff [jbhe_pkg::DcDepth];

   // Sequencer state
   logic                      cur_valid_ff, cur_valid_in;
   logic [1:0]                lead_ff, lead_in;
   logic                      main_ff, main_in;
   logic [1:0]                tail_ff, tail_in;
   logic                      eob_ff, eob_in;
   logic                      main_dc_ff;
   logic [7:0]                sym_ff;
   logic [jbhe_pkg::NbW-1:0]  nb_ff;
   logic [jbhe_pkg::AmpW-1:0] amp_ff;
   logic                      bend_ff;

   // Output stage
   logic                        b_valid_ff, b_valid_in;
   logic                        b_dc_ff;
   logic [jbhe_pkg::NbW-1:0]    b_nb_ff;
   logic [jbhe_pkg::AmpW-1:0]   b_amp_ff;
   logic                        b_end_ff;
   logic [jbhe_pkg::EntryW-1:0] dc_entry_ff;
   logic [jbhe_pkg::EntryW-1:0] ac_entry_ff;
   logic                        ac_hit_ff;

   logic                        emit;
   logic                        last;
   logic                        take;
   logic                        take_code;
   logic                        ac_write;
   logic                        dc_write;
   logic [7:0]                  rd_addr;
   logic                        rd_dc;
   logic [jbhe_pkg::NbW-1:0]    rd_nb;
   logic [jbhe_pkg::AmpW-1:0]   rd_amp;

   logic [jbhe_pkg::EntryW-1:0]   entry;
   logic [jbhe_pkg::LenW-1:0]     len;
   logic [jbhe_pkg::CodeW-1:0]    code;
   logic [jbhe_pkg::AmpW-1:0]     amp_masked;
   logic [jbhe_pkg::ValW-1:0]     val;
   logic [jbhe_pkg::TotW-1:0]     total;

   assign emit = cur_valid_ff && (!b_valid_ff || rsp_pop);

   // Pick the next result of the current job
   always_comb begin
      lead_in = lead_ff;
      main_in = main_ff;
      tail_in = tail_ff;
      eob_in  = eob_ff;
      rd_addr = jbhe_pkg::SYM_ZRL;
      rd_dc   = 1'b0;
      rd_nb   = '0;
      rd_amp  = '0;
      if (lead_ff != 2'd0) begin
         lead_in = lead_ff - 1'b1;
      end else if (main_ff) begin
         main_in = 1'b0;
         rd_addr = sym_ff;
         rd_dc   = main_dc_ff;
         rd_nb   = nb_ff;
         rd_amp  = amp_ff;
      end else if (tail_ff != 2'd0) begin
         tail_in = tail_ff - 1'b1;
      end else begin
         eob_in  = 1'b0;
         rd_addr = jbhe_pkg::SYM_EOB;
      end
      last = (lead_in == 2'd0) && !main_in && (tail_in == 2'd0) && !eob_in;
   end

   // Take the next job when none is active or the current one issues its final result
   assign take      = !job_empty && (!cur_valid_ff || (emit && last));
   assign take_code = take && (job_head.kind == jbhe_pkg::JOB_CODE);
   assign ac_write  = take && (job_head.kind == jbhe_pkg::JOB_AC_WRITE);
   assign dc_write  = take && (job_head.kind == jbhe_pkg::JOB_DC_WRITE);
   assign job_pop   = take;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      if (take) begin
         cur_valid_in = take_code;
      end else if (emit && last) begin
         cur_valid_in = 1'b0;
      end
      b_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         b_valid_ff   <= b_valid_in;
      end
   end

   // Load a new job or step the counters
   always_ff @(posedge clock) begin
      if (take_code) begin
         lead_ff    <= job_head.lead_zrl;
         main_ff    <= job_head.has_main;
         tail_ff    <= job_head.tail_zrl;
         eob_ff     <= job_head.eob;
         main_dc_ff <= job_head.main_dc;
         sym_ff     <= job_head.main_sym;
         nb_ff      <= job_head.nb;
         amp_ff     <= job_head.amp;
         bend_ff    <= job_head.block_end;
      end else if (emit) begin
         lead_ff <= lead_in;
         main_ff <= main_in;
         tail_ff <= tail_in;
         eob_ff  <= eob_in;
      end
   end

   // Table writes; valid bits and DC table reset to empty
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jbhe_pkg::AcDepth; i++) begin
            ac_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < jbhe_pkg::DcDepth; i++) begin
            dc_table_ff[i] <= '0;
         end
      end else begin
         if (ac_write) ac_valid_ff[job_head.wr_addr] <= 1'b1;
         if (dc_write) dc_table_ff[job_head.wr_addr[3:0]] <= job_head.wr_entry;
      end
   end

   // AC table memory with registered read
   always_ff @(posedge clock) begin
      if (ac_write) ac_mem[job_head.wr_addr] <= job_head.wr_entry;
      if (emit) ac_entry_ff <= ac_mem[rd_addr];
   end

   // Capture the issued result
   always_ff @(posedge clock) begin
      if (emit) begin
         ac_hit_ff   <= ac_valid_ff[rd_addr];
         dc_entry_ff <= dc_table_ff[rd_addr[3:0]];
         b_dc_ff     <= rd_dc;
         b_nb_ff     <= rd_nb;
         b_amp_ff    <= rd_amp;
         b_end_ff    <= last && bend_ff;
      end
   end

   // Assemble code and amplitude bits
   always_comb begin
      entry      = b_dc_ff ? dc_entry_ff : (ac_hit_ff ? ac_entry_ff : '0);
      len        = entry[jbhe_pkg::EntryW-1:jbhe_pkg::CodeW];
      code       = entry[jbhe_pkg::CodeW-1:0]
                   & jbhe_pkg::CodeW'((17'(1) << len) - 17'(1));
      amp_masked = b_amp_ff & jbhe_pkg::AmpW'((jbhe_pkg::AmpMaskW'(1) << b_nb_ff)
                                               - jbhe_pkg::AmpMaskW'(1));
      val        = (jbhe_pkg::ValW'(code) << b_nb_ff) | jbhe_pkg::ValW'(amp_masked);
      total      = jbhe_pkg::TotW'(len) + jbhe_pkg::TotW'(b_nb_ff);
      rsp_word.bits      = jbhe_pkg::BitsW'(val);
      rsp_word.bit_count = (total > jbhe_pkg::COUNT_MAX) ? jbhe_pkg::CountW'(jbhe_pkg::BitsW)
                                                        : jbhe_pkg::CountW'(total);
      rsp_word.block_end = b_end_ff;
   end

   assign rsp_empty = !b_valid_ff;

endmodule

@@ rtl/jpeg_block_huffman_encoder.sv @@
// Top level of the JPEG block Huffman encoder: front end, job queue, back end.
//
//   channel   ports                          direction  word
//   request   req_push, req_full, req_word   in         command, coefficient or table entry
//   response  rsp_empty, rsp_pop, rsp_word   out        code bits, bit count, block end
//
// One word is taken per cycle while the four-entry job queue has room.
// The back end gives one result per cycle while responses are popped; a word that makes
// several results (ZRLs, coded term, EOB) holds the back end until all are issued.
// A word's first result passes the job queue, the sequencer and the output register (table read).
// Reset clears predictors, zero run, the DC table, the AC valid bits and all queues.
// A stalled response holds the back end; the front end keeps filling the queue.
module jpeg_block_huffman_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  jbhe_pkg::req_word_type req_word,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output jbhe_pkg::rsp_word_type rsp_word
);

   logic              job_push;
   logic              job_full;
   logic              job_pop;
   logic              job_empty;
   jbhe_pkg::job_type job_in_word;
   jbhe_pkg::job_type job_head;

   assign req_full = job_full;

   jbhe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .job_full (job_full),
      .job_push (job_push),
      .job_word (job_in_word)
   );

   jbhe_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (job_in_word),
      .full      (job_full),
      .pop       (job_pop),
      .head_word (job_head),
      .empty     (job_empty)
   );

   jbhe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_head  (job_head),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // Queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job queue popped while empty");

   // Bit count stays within the word
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_word.bit_count <= jbhe_pkg::CountW'(jbhe_pkg::BitsW)))
      else $error("bit count beyond word width");

   // A fresh response only follows a taken job
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(!job_empty) || $past(!rsp_empty, 2) || $past(job_pop, 2))
      else $error("response without a job");

endmodule
